### hdl/slc_pkg.sv
// Shared types and constants of the set-associative LRU cache tag model.
// No dependencies; used by the row update unit, the top level and the testbench.
`default_nettype none

package slc_pkg;

  localparam int TAG_W    = 32;
  localparam int RANK_W   = 3;
  localparam int LINE_W   = 1 + TAG_W + RANK_W;  // valid, tag, rank
  localparam int CNT_W    = 32;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

  // Register map, word index taken from paddr[3:2].
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_WAYS       = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_IFETCH = 2'd3
  } slc_op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } slc_state_e;

  typedef struct packed {
    logic hit;
    logic miss;
    logic evict;
  } slc_outcome_t;

endpackage

`default_nettype wire

### hdl/slc_req_if.sv
// Request channel of the cache tag model: access kind and byte address.
// Depends on nothing.
`default_nettype none

interface slc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] address;

  modport source (output valid, opcode, address, input ready);
  modport sink   (input valid, opcode, address, output ready);
endinterface

`default_nettype wire

### hdl/slc_rsp_if.sv
// Result channel of the cache tag model: per-access outcome and running totals.
// Depends on nothing.
`default_nettype none

interface slc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  hit_count;
  logic        was_miss;
  logic        was_eviction;
  logic [31:0] total_hits;
  logic [31:0] total_misses;
  logic [31:0] total_evictions;

  modport source (output valid, hit_count, was_miss, was_eviction, total_hits,
                  total_misses, total_evictions, input ready);
  modport sink   (input valid, hit_count, was_miss, was_eviction, total_hits,
                  total_misses, total_evictions, output ready);
endinterface

`default_nettype wire

### hdl/set_assoc_lru_cache_sim.sv
// Set-associative tag cache with true LRU replacement, top level.
// Depends on slc_pkg, slc_req_if, slc_rsp_if, slc_ram and slc_row_upd.
//
// Usage: each request transaction on req carries an opcode (load, store,
// modify, instruction fetch) and a 64-bit byte address. Every request gives
// exactly one response transaction on rsp with the hit count, miss and
// eviction flags of that request and the running 32-bit totals after it.
// Geometry (set_bits, ways, block_bits) is written over the APB port at
// byte addresses 0, 4 and 8; reads return it. The user must write it only
// while the block is idle; the block itself does not enforce this. Each set
// is one row of a RAM with registered read data. A request reads its row in
// the accept cycle and does a read-modify-write in the next one (a modify
// does a second pass on the row held in a register); the result then goes
// through the done state into the output register. After reset the block
// clears the row RAM, one row per cycle through all 2**MAX_SET_BITS rows
// (64 by default), with req.ready low; APB writes are taken during that
// time. The output register holds a result while rsp is stalled; the next
// request is accepted meanwhile and waits for it to drain.
`default_nettype none

module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  slc_req_if.sink                           req,
  slc_rsp_if.source                         rsp,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [slc_pkg::APB_AW-1:0]   paddr,
  input  wire logic [slc_pkg::APB_DW-1:0]   pwdata,
  output logic      [slc_pkg::APB_DW-1:0]   prdata,
  output logic                              pready
);

  localparam int RowW  = MAX_WAYS * slc_pkg::LINE_W;
  localparam int Depth = 1 << MAX_SET_BITS;
  localparam int TW    = slc_pkg::TAG_W;
  localparam int CW    = slc_pkg::CNT_W;

  // Configuration
  logic [2:0] set_bits_q;
  logic [3:0] ways_q;
  logic [4:0] blk_bits_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= 3'd1;
      ways_q     <= 4'd1;
      blk_bits_q <= 5'd1;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        slc_pkg::REG_SET_BITS:   set_bits_q <= pwdata[2:0];
        slc_pkg::REG_WAYS:       ways_q     <= pwdata[3:0];
        slc_pkg::REG_BLOCK_BITS: blk_bits_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      slc_pkg::REG_SET_BITS:   prdata = {29'd0, set_bits_q};
      slc_pkg::REG_WAYS:       prdata = {28'd0, ways_q};
      slc_pkg::REG_BLOCK_BITS: prdata = {27'd0, blk_bits_q};
      default:                 prdata = '0;
    endcase
  end

  // Effective geometry
  logic [2:0]              sb;
  logic [3:0]              nways;
  logic [MAX_SET_BITS-1:0] set_mask;

  always_comb begin
    sb = (int'(set_bits_q) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_q;
    if (ways_q == 4'd0) begin
      nways = 4'd1;
    end else if (int'(ways_q) > MAX_WAYS) begin
      nways = 4'(MAX_WAYS);
    end else begin
      nways = ways_q;
    end
    set_mask = ~({MAX_SET_BITS{1'b1}} << sb);
  end

  // Address split of the incoming request
  logic [63:0]             shifted_in, tag_shift;
  logic [MAX_SET_BITS-1:0] set_in;
  logic [TW-1:0]           tag_in;

  assign shifted_in = req.address >> blk_bits_q;
  assign tag_shift  = shifted_in >> sb;
  assign set_in     = shifted_in[MAX_SET_BITS-1:0] & set_mask;
  assign tag_in     = tag_shift[TW-1:0];

  // Control
  slc_pkg::slc_state_e     state_q, state_d;
  logic [MAX_SET_BITS-1:0] clr_q, clr_d;
  logic [MAX_SET_BITS-1:0] set_q;
  logic [TW-1:0]           tag_q;
  slc_pkg::slc_op_e        op_q;
  logic                    pass_q, pass_d;
  logic [RowW-1:0]         row_q;
  logic [1:0]              hcnt_q, hcnt_d;
  logic                    miss_q, miss_d, evict_q, evict_d;
  logic [CW-1:0]           hits_q, hits_d, misses_q, misses_d, evicts_q, evicts_d;
  logic                    out_vld_q, out_vld_d, out_load;
  logic                    accept;

  // Row RAM
  logic                    ram_we;
  logic [MAX_SET_BITS-1:0] ram_waddr;
  logic [RowW-1:0]         ram_wdata, ram_rdata, src_row, new_row;
  slc_pkg::slc_outcome_t   outcome;

  assign req.ready = (state_q == slc_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;

  slc_ram #(
    .WIDTH (RowW),
    .DEPTH (Depth)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (set_in),
    .rdata_o (ram_rdata)
  );

  // The second pass of a modify works on the row just written.
  assign src_row = pass_q ? row_q : ram_rdata;

  slc_row_upd #(
    .MAX_WAYS (MAX_WAYS)
  ) u_row_upd (
    .row_i     (src_row),
    .tag_i     (tag_q),
    .nways_i   (nways),
    .row_o     (new_row),
    .outcome_o (outcome)
  );

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    pass_d    = pass_q;
    hcnt_d    = hcnt_q;
    miss_d    = miss_q;
    evict_d   = evict_q;
    hits_d    = hits_q;
    misses_d  = misses_q;
    evicts_d  = evicts_q;
    ram_we    = 1'b0;
    ram_waddr = set_q;
    ram_wdata = new_row;
    out_load  = 1'b0;
    unique case (state_q)
      slc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + MAX_SET_BITS'(1);
        if (&clr_q) state_d = slc_pkg::ST_IDLE;
      end
      slc_pkg::ST_IDLE: begin
        if (accept) begin
          pass_d  = 1'b0;
          hcnt_d  = 2'd0;
          miss_d  = 1'b0;
          evict_d = 1'b0;
          state_d = (slc_pkg::slc_op_e'(req.opcode) == slc_pkg::OP_IFETCH) ?
                    slc_pkg::ST_DONE : slc_pkg::ST_CALC;
        end
      end
      slc_pkg::ST_CALC: begin
        ram_we   = 1'b1;
        hcnt_d   = hcnt_q + {1'b0, outcome.hit};
        miss_d   = miss_q | outcome.miss;
        evict_d  = evict_q | outcome.evict;
        hits_d   = hits_q + CW'(outcome.hit);
        misses_d = misses_q + CW'(outcome.miss);
        evicts_d = evicts_q + CW'(outcome.evict);
        if ((op_q == slc_pkg::OP_MODIFY) && !pass_q) begin
          pass_d = 1'b1;
        end else begin
          state_d = slc_pkg::ST_DONE;
        end
      end
      slc_pkg::ST_DONE: begin
        if (!out_vld_q || rsp.ready) begin
          out_load = 1'b1;
          state_d  = slc_pkg::ST_IDLE;
        end
      end
      default: state_d = slc_pkg::ST_IDLE;
    endcase
    out_vld_d = out_load || (out_vld_q && !rsp.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= slc_pkg::ST_CLEAR;
      clr_q     <= '0;
      pass_q    <= 1'b0;
      hcnt_q    <= 2'd0;
      miss_q    <= 1'b0;
      evict_q   <= 1'b0;
      hits_q    <= '0;
      misses_q  <= '0;
      evicts_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      pass_q    <= pass_d;
      hcnt_q    <= hcnt_d;
      miss_q    <= miss_d;
      evict_q   <= evict_d;
      hits_q    <= hits_d;
      misses_q  <= misses_d;
      evicts_q  <= evicts_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  logic [1:0]    out_hcnt_q;
  logic          out_miss_q, out_evict_q;
  logic [CW-1:0] out_hits_q, out_misses_q, out_evicts_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q <= set_in;
      tag_q <= tag_in;
      op_q  <= slc_pkg::slc_op_e'(req.opcode);
    end
    if (state_q == slc_pkg::ST_CALC) begin
      row_q <= new_row;
    end
    if (out_load) begin
      out_hcnt_q   <= hcnt_q;
      out_miss_q   <= miss_q;
      out_evict_q  <= evict_q;
      out_hits_q   <= hits_q;
      out_misses_q <= misses_q;
      out_evicts_q <= evicts_q;
    end
  end

  assign rsp.valid           = out_vld_q;
  assign rsp.hit_count       = out_hcnt_q;
  assign rsp.was_miss        = out_miss_q;
  assign rsp.was_eviction    = out_evict_q;
  assign rsp.total_hits      = out_hits_q;
  assign rsp.total_misses    = out_misses_q;
  assign rsp.total_evictions = out_evicts_q;

  // Assertions
  a_evict_needs_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !(rsp.was_eviction && !rsp.was_miss))
    else $error("eviction reported without a miss");

  a_two_hits_no_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && (rsp.hit_count == 2'd2)) |-> !rsp.was_miss)
    else $error("two hits and a miss in one transaction");

  a_one_access_per_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == slc_pkg::ST_CALC) |=>
      ((hits_q + misses_q) == ($past(hits_q + misses_q) + 32'd1)))
    else $error("hit and miss totals did not advance by one per access");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == slc_pkg::ST_CLEAR) |=> !$past(accept) && (out_vld_q == $past(out_vld_q)))
    else $error("activity during row clearing");

endmodule

`default_nettype wire

### hdl/slc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module slc_ram #(
  parameter int WIDTH = 288,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hdl/slc_row_upd.sv
// Lookup and LRU update of one set row: hit search, fill or victim choice, rank aging.
// Depends on slc_pkg.
`default_nettype none

module slc_row_upd #(
  parameter int MAX_WAYS = 8
) (
  input  wire logic [MAX_WAYS*slc_pkg::LINE_W-1:0] row_i,
  input  wire logic [slc_pkg::TAG_W-1:0]           tag_i,
  input  wire logic [3:0]                          nways_i,
  output logic      [MAX_WAYS*slc_pkg::LINE_W-1:0] row_o,
  output slc_pkg::slc_outcome_t                    outcome_o
);

  localparam int WIdxW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LW    = slc_pkg::LINE_W;
  localparam int RW    = slc_pkg::RANK_W;
  localparam int TW    = slc_pkg::TAG_W;

  logic              vld   [MAX_WAYS];
  logic [TW-1:0]     tg    [MAX_WAYS];
  logic [RW-1:0]     rk    [MAX_WAYS];
  logic [MAX_WAYS-1:0] in_use, hit_vec, inv_vec;

  logic              any_hit, any_inv;
  logic [WIdxW-1:0]  hit_way, inv_way, victim, mru;
  logic [RW-1:0]     best;
  logic [RW:0]       limit;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      vld[w]     = row_i[w*LW + LW - 1];
      tg[w]      = row_i[w*LW + RW +: TW];
      rk[w]      = row_i[w*LW +: RW];
      in_use[w]  = (w < int'(nways_i));
      hit_vec[w] = in_use[w] && vld[w] && (tg[w] == tag_i);
      inv_vec[w] = in_use[w] && !vld[w];
    end
  end

  // Lowest-numbered hit and invalid way; oldest way, lowest index on ties.
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = WIdxW'(w);
      if (inv_vec[w]) inv_way = WIdxW'(w);
    end
    any_hit = |hit_vec;
    any_inv = |inv_vec;
    victim  = '0;
    best    = rk[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && (rk[w] > best)) begin
        best   = rk[w];
        victim = WIdxW'(w);
      end
    end
  end

  always_comb begin
    if (any_hit) begin
      mru   = hit_way;
      limit = {1'b0, rk[hit_way]};
    end else begin
      mru   = any_inv ? inv_way : victim;
      limit = {1'b1, {RW{1'b0}}};
    end
    row_o = row_i;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WIdxW'(w) == mru) begin
        row_o[w*LW +: LW] = {1'b1, tag_i, {RW{1'b0}}};
      end else if (in_use[w] && vld[w] && ({1'b0, rk[w]} < limit) &&
                   (rk[w] < slc_pkg::RANK_MAX)) begin
        row_o[w*LW +: RW] = rk[w] + RW'(1);
      end
    end
    outcome_o.hit   = any_hit;
    outcome_o.miss  = !any_hit;
    outcome_o.evict = !any_hit && !any_inv;
  end

endmodule

`default_nettype wire

### tb/slc_cache_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the LRU cache tag model: watches req, rsp and the APB writes,
// predicts each response from its own tag store. Depends on slc_pkg, slc_req_if, slc_rsp_if.
module slc_cache_checker #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  slc_req_if                              req,
  slc_rsp_if                              rsp,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic                       pready,
  input  wire logic [slc_pkg::APB_AW-1:0] paddr,
  input  wire logic [slc_pkg::APB_DW-1:0] pwdata,
  output int                              fail_count_o,
  output int                              pending_o
);

  localparam int LINES = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int CW    = slc_pkg::CNT_W;
  localparam int TW    = slc_pkg::TAG_W;
  localparam int RW    = slc_pkg::RANK_W;

  typedef struct packed {
    logic [1:0]    hit_count;
    logic          was_miss;
    logic          was_eviction;
    logic [CW-1:0] total_hits;
    logic [CW-1:0] total_misses;
    logic [CW-1:0] total_evictions;
  } slc_result_t;

  logic          line_valid_q [LINES];
  logic [TW-1:0] line_tag_q   [LINES];
  logic [RW-1:0] line_rank_q  [LINES];
  logic [CW-1:0] hits_q, misses_q, evicts_q;
  logic [2:0]    cfg_set_bits;
  logic [3:0]    cfg_ways;
  logic [4:0]    cfg_block_bits;
  slc_result_t   outcome_q [$];
  int unsigned   rsp_idx;
  int            fails;

  assign fail_count_o = fails;

  task automatic report(string msg);
    fails++;
    $display("[%0t] MISMATCH rsp #%0d: %s", $realtime, rsp_idx, msg);
  endtask

  task automatic check_field(string name, logic [CW-1:0] got, logic [CW-1:0] want);
    if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Age the in-use valid ways of a set that rank below limit, then make mru the newest.
  function automatic void age_set(int unsigned base, int unsigned nw, int unsigned mru,
                                  int unsigned limit);
    for (int unsigned w = 0; w < nw; w++) begin
      if (w != mru && line_valid_q[base+w] && line_rank_q[base+w] < limit &&
          line_rank_q[base+w] < slc_pkg::RANK_MAX)
        line_rank_q[base+w] = line_rank_q[base+w] + 3'd1;
    end
    line_rank_q[base+mru] = '0;
  endfunction

  function automatic slc_pkg::slc_outcome_t lookup_line(logic [63:0] addr);
    int unsigned           sb, nw, base, set_idx, victim;
    logic [63:0]           shifted;
    logic [TW-1:0]         tag;
    logic [RW-1:0]         best;
    slc_pkg::slc_outcome_t res;
    sb      = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
    nw      = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS) ? MAX_WAYS : cfg_ways);
    shifted = addr >> cfg_block_bits;
    set_idx = int'(shifted & ((64'd1 << sb) - 64'd1));
    tag     = TW'(shifted >> sb);
    base    = set_idx * MAX_WAYS;
    res     = '0;
    for (int unsigned w = 0; w < nw; w++) begin
      if (line_valid_q[base+w] && line_tag_q[base+w] == tag) begin
        age_set(base, nw, w, line_rank_q[base+w]);
        hits_q++;
        res.hit = 1'b1;
        return res;
      end
    end
    misses_q++;
    res.miss = 1'b1;
    for (int unsigned w = 0; w < nw; w++) begin
      if (!line_valid_q[base+w]) begin
        line_valid_q[base+w] = 1'b1;
        line_tag_q[base+w]   = tag;
        age_set(base, nw, w, slc_pkg::RANK_MAX + 1);
        return res;
      end
    end
    // set full: oldest rank goes, lowest way on a tie
    victim = 0;
    best   = line_rank_q[base];
    for (int unsigned w = 1; w < nw; w++) begin
      if (line_rank_q[base+w] > best) begin
        best   = line_rank_q[base+w];
        victim = w;
      end
    end
    line_tag_q[base+victim] = tag;
    age_set(base, nw, victim, slc_pkg::RANK_MAX + 1);
    evicts_q++;
    res.evict = 1'b1;
    return res;
  endfunction

  task automatic predict_access(slc_pkg::slc_op_e op, logic [63:0] addr);
    slc_pkg::slc_outcome_t first, second;
    slc_result_t           exp;
    exp = '0;
    if (op != slc_pkg::OP_IFETCH) begin
      first            = lookup_line(addr);
      exp.hit_count    = {1'b0, first.hit};
      exp.was_miss     = first.miss;
      exp.was_eviction = first.evict;
      if (op == slc_pkg::OP_MODIFY) begin
        second           = lookup_line(addr);
        exp.hit_count    = exp.hit_count + {1'b0, second.hit};
        exp.was_miss     = exp.was_miss | second.miss;
        exp.was_eviction = exp.was_eviction | second.evict;
      end
    end
    exp.total_hits      = hits_q;
    exp.total_misses    = misses_q;
    exp.total_evictions = evicts_q;
    outcome_q.push_back(exp);
  endtask

  task automatic check_response();
    slc_result_t exp;
    if (outcome_q.size() == 0) begin
      report("response transaction with nothing expected");
    end else begin
      exp = outcome_q.pop_front();
      check_field("hit_count", CW'(rsp.hit_count), CW'(exp.hit_count));
      check_field("was_miss", CW'(rsp.was_miss), CW'(exp.was_miss));
      check_field("was_eviction", CW'(rsp.was_eviction), CW'(exp.was_eviction));
      check_field("total_hits", rsp.total_hits, exp.total_hits);
      check_field("total_misses", rsp.total_misses, exp.total_misses);
      check_field("total_evictions", rsp.total_evictions, exp.total_evictions);
    end
    rsp_idx++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LINES; i++) begin
        line_valid_q[i] = 1'b0;
        line_tag_q[i]   = '0;
        line_rank_q[i]  = '0;
      end
      hits_q         = '0;
      misses_q       = '0;
      evicts_q       = '0;
      cfg_set_bits   = 3'd1;
      cfg_ways       = 4'd1;
      cfg_block_bits = 5'd1;
      outcome_q.delete();
      rsp_idx        = 0;
    end else begin
      // a response never belongs to a request taken at the same edge
      if (rsp.valid && rsp.ready) check_response();
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[3:2])
          slc_pkg::REG_SET_BITS:   cfg_set_bits   = pwdata[2:0];
          slc_pkg::REG_WAYS:       cfg_ways       = pwdata[3:0];
          slc_pkg::REG_BLOCK_BITS: cfg_block_bits = pwdata[4:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        predict_access(slc_pkg::slc_op_e'(req.opcode), req.address);
      end
    end
    pending_o = outcome_q.size();
  end

  initial fails = 0;

endmodule

### tb/tb_set_assoc_lru_cache_sim.sv
`timescale 1ns / 100ps
// Top of the cache tag model testbench: clock, reset, APB geometry writes, request
// and response traffic. Depends on slc_pkg, the channel interfaces, the block
// and slc_cache_checker.
module tb_set_assoc_lru_cache_sim;

  localparam int MAX_SET_BITS_C = 6;
  localparam int MAX_WAYS_C     = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_STALL     = 300;
  localparam int DRAIN_CYCLES   = 12;
  localparam int PHASE_ITEMS    = 72;

  logic                       clk;
  logic                       rst_n;
  logic                       psel, penable, pwrite;
  logic [slc_pkg::APB_AW-1:0] paddr;
  logic [slc_pkg::APB_DW-1:0] pwdata;
  logic [slc_pkg::APB_DW-1:0] prdata;
  logic                       pready;
  int                         fail_count;
  int                         pending;

  logic [2:0] cur_set_bits;
  logic [3:0] cur_ways;
  logic [4:0] cur_block_bits;
  int         src_idle_pct;
  int         sink_stall_pct;
  bit         pressure_on;
  bit         pressure_done;
  int         held_cycles;
  int         quiet_cycles;

  slc_req_if req_if ();
  slc_rsp_if rsp_if ();

  set_assoc_lru_cache_sim #(
    .MAX_SET_BITS(MAX_SET_BITS_C),
    .MAX_WAYS    (MAX_WAYS_C)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req    (req_if),
    .rsp    (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  slc_cache_checker #(
    .MAX_SET_BITS(MAX_SET_BITS_C),
    .MAX_WAYS    (MAX_WAYS_C)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req         (req_if),
    .rsp         (rsp_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // response side: random stall, plus one long hold-off while requests keep coming
  initial begin
    rsp_if.ready  = 1'b0;
    pressure_done = 1'b0;
    held_cycles   = 0;
    forever begin
      @(posedge clk);
      if (pressure_on && !pressure_done) begin
        rsp_if.ready <= 1'b0;
        held_cycles++;
        if (held_cycles >= LONG_STALL) pressure_done = 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // ends the run when no transaction has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic int unsigned eff_set_bits();
    return (cur_set_bits > MAX_SET_BITS_C) ? MAX_SET_BITS_C : cur_set_bits;
  endfunction

  function automatic int unsigned eff_ways();
    return (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS_C) ? MAX_WAYS_C : cur_ways);
  endfunction

  // Tag and set land in their fields; offset and bits above the tag stay random.
  function automatic logic [63:0] make_address(logic [31:0] tag, int unsigned set_idx);
    logic [63:0] noise, field, mask;
    int unsigned sb;
    sb    = eff_set_bits();
    noise = {$urandom(), $urandom()};
    field = ({32'd0, tag} << sb) | 64'(set_idx);
    mask  = ((64'd1 << (32 + sb)) - 64'd1) << cur_block_bits;
    return (noise & ~mask) | ((field << cur_block_bits) & mask);
  endfunction

  task automatic apb_write(logic [1:0] reg_idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(logic [2:0] sb, logic [3:0] nw, logic [4:0] bb);
    apb_write(slc_pkg::REG_SET_BITS, ($urandom() << 5) | 32'(sb));
    apb_write(slc_pkg::REG_WAYS, ($urandom() << 5) | 32'(nw));
    apb_write(slc_pkg::REG_BLOCK_BITS, ($urandom() << 5) | 32'(bb));
    cur_set_bits   = sb;
    cur_ways       = nw;
    cur_block_bits = bb;
  endtask

  task automatic send_access(slc_pkg::slc_op_e op, logic [63:0] addr);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.opcode  <= op;
    req_if.address <= addr;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_random_phase(int unsigned count);
    logic [31:0]      tag_pool [10];
    int unsigned      pool_n, nsets, hot_a, hot_b, set_idx, pick;
    logic [63:0]      addr;
    slc_pkg::slc_op_e op;
    nsets  = 1 << eff_set_bits();
    pool_n = eff_ways() + 2;
    for (int k = 0; k < 10; k++) tag_pool[k] = $urandom();
    if ($urandom_range(1) == 1) begin
      tag_pool[0] = '0;
      tag_pool[1] = '1;
    end
    // a couple of hot sets so that fills turn into evictions
    hot_a = $urandom_range(nsets - 1);
    hot_b = $urandom_range(nsets - 1);
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 30)      op = slc_pkg::OP_LOAD;
      else if (pick < 55) op = slc_pkg::OP_STORE;
      else if (pick < 85) op = slc_pkg::OP_MODIFY;
      else                op = slc_pkg::OP_IFETCH;
      pick = $urandom_range(99);
      if (pick < 8) begin
        addr = {$urandom(), $urandom()};
      end else begin
        if (pick < 50)      set_idx = hot_a;
        else if (pick < 80) set_idx = hot_b;
        else                set_idx = $urandom_range(nsets - 1);
        addr = make_address(tag_pool[$urandom_range(pool_n - 1)], set_idx);
      end
      send_access(op, addr);
    end
  endtask

  task automatic start_phase(logic [2:0] sb, logic [3:0] nw, logic [4:0] bb,
                             int src_pct, int sink_pct);
    wait_results_drained();
    set_geometry(sb, nw, bb);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  initial begin
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_if.valid   = 1'b0;
    req_if.opcode  = slc_pkg::OP_LOAD;
    req_if.address = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    pressure_on    = 1'b0;
    cur_set_bits   = 3'd1;
    cur_ways       = 4'd1;
    cur_block_bits = 5'd1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 4 sets, 4 ways, 16-byte blocks; fill set 0 past capacity
    set_geometry(3'd2, 4'd4, 5'd4);
    send_access(slc_pkg::OP_IFETCH, 64'd0);
    send_access(slc_pkg::OP_LOAD, make_address(32'd1, 0));
    send_access(slc_pkg::OP_LOAD, make_address(32'd1, 0));
    send_access(slc_pkg::OP_STORE, make_address(32'd1, 0));
    send_access(slc_pkg::OP_MODIFY, make_address(32'd2, 0));
    send_access(slc_pkg::OP_MODIFY, make_address(32'd2, 0));
    send_access(slc_pkg::OP_LOAD, make_address(32'd3, 0));
    send_access(slc_pkg::OP_STORE, make_address(32'd4, 0));
    send_access(slc_pkg::OP_LOAD, make_address(32'd5, 0));
    send_access(slc_pkg::OP_MODIFY, make_address(32'd1, 0));
    send_access(slc_pkg::OP_LOAD, make_address(32'd3, 0));
    send_access(slc_pkg::OP_IFETCH, '1);
    send_access(slc_pkg::OP_LOAD, '1);
    send_access(slc_pkg::OP_STORE, '1);
    send_access(slc_pkg::OP_MODIFY, 64'h8000_0000_0000_0000);
    send_access(slc_pkg::OP_LOAD, make_address(32'hFFFF_FFFF, 2));
    send_access(slc_pkg::OP_LOAD, make_address(32'd0, 2));
    send_access(slc_pkg::OP_STORE, 64'd0);

    // random phases; lines stay valid across geometry changes
    start_phase(3'd2, 4'd4, 5'd4, 0, 0);
    run_random_phase(PHASE_ITEMS);
    start_phase(3'd0, 4'd1, 5'd0, 66, 0);
    run_random_phase(PHASE_ITEMS);
    start_phase(3'd6, 4'd8, 5'd16, 0, 66);
    run_random_phase(PHASE_ITEMS);
    start_phase(3'd7, 4'd15, 5'd31, 19, 19);
    run_random_phase(PHASE_ITEMS);
    start_phase(3'd3, 4'd0, 5'd5, 0, 0);
    pressure_on = 1'b1;
    run_random_phase(PHASE_ITEMS);
    start_phase(3'd1, 4'd2, 5'd1, 66, 66);
    run_random_phase(PHASE_ITEMS);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
